// File: rtl/redo_block_header_checker_macros.svh
// Assertion macros for the checker file rbhc_checker.sv.
`ifndef REDO_BLOCK_HEADER_CHECKER_MACROS_SVH
`define REDO_BLOCK_HEADER_CHECKER_MACROS_SVH

// The condition must hold whenever the antecedent holds, in the same cycle.
`define RBHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the antecedent.
`define RBHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rbhc_pkg.sv
package rbhc_pkg;

  localparam int unsigned MaxBlockWords = 512;
  localparam int unsigned WordsW = 10;

  localparam logic [8:0] LastWordIndex = 9'd511;

  localparam logic [7:0] MarkerSmall = 8'h22;
  localparam logic [7:0] MarkerLarge = 8'h82;

  localparam logic [1:0] SizeCode512 = 2'd0;
  localparam logic [1:0] SizeCode1k  = 2'd1;
  localparam logic [1:0] SizeCode4k  = 2'd2;
  localparam logic [1:0] SizeCodeBad = 2'd3;

  localparam logic [7:0] CfgIdxBlockSize = 8'd0;
  localparam logic [7:0] CfgIdxArchive   = 8'd1;
  localparam logic [7:0] CfgIdxChecksum  = 8'd2;
  localparam logic [7:0] CfgIdxBigEndian = 8'd3;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StEmpty       = 3'd1,
    StBadData     = 3'd2,
    StSeqError    = 3'd3,
    StOverwritten = 3'd4,
    StBlockError  = 3'd5,
    StChecksumErr = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0] block_size_code;
    logic       archive_mode;
    logic       checksum_enable;
    logic       big_endian;
  } cfg_t;

  typedef struct packed {
    logic [63:0] header_zero;
    logic [63:0] header_one;
    logic [63:0] xor_acc;
  } blk_view_t;

  function automatic logic [WordsW-1:0] block_words(input logic [1:0] code);
    logic [WordsW-1:0] n;
    unique case (code)
      SizeCode1k: n = WordsW'(1024 / 8);
      SizeCode4k: n = WordsW'(4096 / 8);
      default:    n = WordsW'(512 / 8);
    endcase
    if (n > WordsW'(MaxBlockWords)) begin
      n = WordsW'(MaxBlockWords);
    end
    return n;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

// File: rtl/rbhc_accum.sv
module rbhc_accum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [63:0]           word_i,
  input  logic                  last_i,
  input  logic [1:0]            size_code_i,
  output rbhc_pkg::blk_view_t   view_o
);
  import rbhc_pkg::*;

  logic [8:0]  idx_q, idx_d;
  logic        past_end_q, past_end_d;
  logic [63:0] hw0_q, hw0_d;
  logic [63:0] hw1_q, hw1_d;
  logic [63:0] acc_q, acc_d;

  always_comb begin
    idx_d      = idx_q;
    past_end_d = past_end_q;
    hw0_d      = hw0_q;
    hw1_d      = hw1_q;
    acc_d      = acc_q;
    if (!past_end_q) begin
      if (idx_q == 9'd0) begin
        hw0_d = word_i;
      end
      if (idx_q == 9'd1) begin
        hw1_d = word_i;
      end
      if ({1'b0, idx_q} < block_words(size_code_i)) begin
        acc_d = acc_q ^ word_i;
      end
      if (idx_q < LastWordIndex) begin
        idx_d = idx_q + 9'd1;
      end else begin
        past_end_d = 1'b1;
      end
    end
  end

  assign view_o = '{header_zero: hw0_d, header_one: hw1_d, xor_acc: acc_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      past_end_q <= 1'b0;
      hw0_q      <= '0;
      hw1_q      <= '0;
      acc_q      <= '0;
    end else if (advance_i) begin
      if (last_i) begin
        idx_q      <= '0;
        past_end_q <= 1'b0;
        hw0_q      <= '0;
        hw1_q      <= '0;
        acc_q      <= '0;
      end else begin
        idx_q      <= idx_d;
        past_end_q <= past_end_d;
        hw0_q      <= hw0_d;
        hw1_q      <= hw1_d;
        acc_q      <= acc_d;
      end
    end
  end

endmodule

// File: rtl/rbhc_eval.sv
module rbhc_eval (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  finish_i,
  input  rbhc_pkg::blk_view_t   view_i,
  input  logic [31:0]           expected_i,
  input  logic                  resync_i,
  input  rbhc_pkg::cfg_t        cfg_i,
  output rbhc_pkg::status_e     status_o,
  output logic [31:0]           sequence_o,
  output logic [15:0]           sum_o
);
  import rbhc_pkg::*;

  logic [31:0] seq_q, seq_d;
  logic [7:0]  b0, b1, marker;
  logic [31:0] blk, seq;
  logic [15:0] stored_sum, fold, fold_raw;

  assign b0       = view_i.header_zero[7:0];
  assign b1       = view_i.header_zero[15:8];
  assign blk      = cfg_i.big_endian ? swap32(view_i.header_zero[63:32])
                                     : view_i.header_zero[63:32];
  assign seq      = cfg_i.big_endian ? swap32(view_i.header_one[31:0])
                                     : view_i.header_one[31:0];
  assign stored_sum = cfg_i.big_endian ? swap16(view_i.header_one[63:48])
                                       : view_i.header_one[63:48];
  assign fold_raw = view_i.xor_acc[15:0] ^ view_i.xor_acc[31:16] ^
                    view_i.xor_acc[47:32] ^ view_i.xor_acc[63:48];
  assign fold     = cfg_i.big_endian ? swap16(fold_raw) : fold_raw;
  assign sum_o    = fold ^ stored_sum;
  assign marker   = (cfg_i.block_size_code == SizeCode4k) ? MarkerLarge : MarkerSmall;

  always_comb begin
    seq_d    = seq_q;
    status_o = StOk;
    if (b0 == 8'h00 && b1 == 8'h00) begin
      status_o = StEmpty;
    end else if (cfg_i.block_size_code == SizeCodeBad || b1 != marker) begin
      status_o = StBadData;
    end else begin
      if (seq_q == 32'd0 || resync_i) begin
        seq_d = seq;
      end else if (cfg_i.archive_mode) begin
        if (seq_q != seq) begin
          status_o = StSeqError;
        end
      end else if (seq_q > seq) begin
        status_o = StEmpty;
      end else if (seq_q < seq) begin
        status_o = StOverwritten;
      end
      if (status_o == StOk && blk != expected_i) begin
        status_o = StBlockError;
      end
      if (status_o == StOk && cfg_i.checksum_enable && sum_o != stored_sum) begin
        status_o = StChecksumErr;
      end
    end
  end

  assign sequence_o = seq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (finish_i) begin
      seq_q <= seq_d;
    end
  end

endmodule

// File: rtl/redo_block_header_checker.sv
// Log block header checker. Block words enter one per cycle as 64-bit
// transactions, the last word flagged, and each block gives one status
// transaction, which passes the input register and then the status output
// register after its last word is accepted. A word sits in an input register
// and then folds into the XOR accumulator and header registers, so the input
// side takes a word every cycle; it stalls only while a last word waits behind
// a status that has not been taken. Configuration is taken every cycle and
// must be written between blocks.
module redo_block_header_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic        word_last_i,
  input  logic [31:0] expected_block_i,
  input  logic        resync_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  check_status_o,
  output logic [31:0] current_sequence_o,
  output logic [15:0] computed_sum_o
);
  import rbhc_pkg::*;

  cfg_t        cfg_q;
  logic        a_valid_q;
  logic [63:0] a_word_q;
  logic        a_last_q;
  logic [31:0] a_expected_q;
  logic        a_resync_q;
  logic        out_valid_q;
  status_e     status_q;
  logic [31:0] seq_out_q;
  logic [15:0] sum_q;

  logic        in_fire, a_advance, out_free, finish;
  blk_view_t   view;
  status_e     status;
  logic [31:0] seq_next;
  logic [15:0] sum;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign a_advance   = a_valid_q && (!a_last_q || out_free);
  assign finish      = a_advance && a_last_q;
  assign in_ready_o  = !a_valid_q || a_advance;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{block_size_code: SizeCode512, archive_mode: 1'b1,
                 checksum_enable: 1'b1, big_endian: 1'b0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgIdxBlockSize: cfg_q.block_size_code <= cfg_data_i[1:0];
        CfgIdxArchive:   cfg_q.archive_mode    <= cfg_data_i[0];
        CfgIdxChecksum:  cfg_q.checksum_enable <= cfg_data_i[0];
        CfgIdxBigEndian: cfg_q.big_endian      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (a_advance) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_word_q     <= data_word_i;
      a_last_q     <= word_last_i;
      a_expected_q <= expected_block_i;
      a_resync_q   <= resync_i;
    end
  end

  rbhc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (a_advance),
    .word_i      (a_word_q),
    .last_i      (a_last_q),
    .size_code_i (cfg_q.block_size_code),
    .view_o      (view)
  );

  rbhc_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .finish_i   (finish),
    .view_i     (view),
    .expected_i (a_expected_q),
    .resync_i   (a_resync_q),
    .cfg_i      (cfg_q),
    .status_o   (status),
    .sequence_o (seq_next),
    .sum_o      (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      status_q  <= status;
      seq_out_q <= seq_next;
      sum_q     <= sum;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign check_status_o     = status_q;
  assign current_sequence_o = seq_out_q;
  assign computed_sum_o     = sum_q;

endmodule

// File: rtl/rbhc_checker.sv
`include "redo_block_header_checker_macros.svh"

module rbhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  check_status_o,
  input logic [31:0] current_sequence_o,
  input logic [15:0] computed_sum_o
);

  // A held status transaction keeps its payload until it is taken.
  `RBHC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(check_status_o) && $stable(current_sequence_o) &&
    $stable(computed_sum_o), "status transaction changed while stalled")

  // The input side may only stall behind a status that is not taken.
  `RBHC_ASSERT_NOW(a_in_stall, !in_ready_o, out_valid_o && !out_ready_i,
    "input stalled without a pending status")

  // Status code seven is never produced.
  `RBHC_ASSERT_NOW(a_status_range, out_valid_o, check_status_o != 3'd7,
    "undefined status code")

endmodule

bind redo_block_header_checker rbhc_checker u_rbhc_checker (.*);

// File: verif/tb_redo_block_header_checker.sv
`timescale 1ns / 100ps

module tb_redo_block_header_checker;
  import rbhc_pkg::*;

  typedef enum logic [1:0] {
    SumRandom,
    SumGood,
    SumBad
  } sum_mode_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] seq;
    logic [15:0] sum;
  } verdict_t;

  typedef struct packed {
    logic [1:0]  size_code;
    logic        archive;
    logic        cks_en;
    logic        big_end;
    logic [1:0]  words;
    logic [7:0]  b0;
    logic [7:0]  marker;
    logic [31:0] blk;
    logic [31:0] seq;
    logic [31:0] exp_blk;
    logic        resync;
    sum_mode_e   sum_mode;
    logic        pinned;
    status_e     status;
  } row_t;

  localparam int QuietLimit = 4000;

  // Short blocks for the header checks; a pinned row carries its status.
  localparam row_t Plan [15] = '{
    '{SizeCode512, 1'b1, 1'b1, 1'b0, 2'd1, 8'h00, 8'h00, 32'd0, 32'd0, 32'd0,
      1'b0, SumGood, 1'b1, StEmpty},
    '{SizeCode512, 1'b1, 1'b1, 1'b0, 2'd1, 8'h01, 8'h82, 32'd0, 32'd0, 32'd0,
      1'b0, SumGood, 1'b1, StBadData},
    '{SizeCode512, 1'b1, 1'b1, 1'b0, 2'd2, 8'h01, 8'h22, 32'd7, 32'h100, 32'd7,
      1'b0, SumGood, 1'b1, StOk},
    '{SizeCode512, 1'b1, 1'b1, 1'b0, 2'd2, 8'h01, 8'h22, 32'd7, 32'h101, 32'd7,
      1'b0, SumGood, 1'b1, StSeqError},
    '{SizeCode512, 1'b1, 1'b1, 1'b0, 2'd2, 8'h01, 8'h22, 32'd8, 32'h100, 32'd7,
      1'b0, SumGood, 1'b1, StBlockError},
    '{SizeCode512, 1'b1, 1'b1, 1'b0, 2'd2, 8'h01, 8'h22, 32'd7, 32'h100, 32'd7,
      1'b0, SumBad, 1'b1, StChecksumErr},
    '{SizeCode1k, 1'b0, 1'b1, 1'b0, 2'd2, 8'h01, 8'h22, 32'd7, 32'h0FF, 32'd7,
      1'b0, SumGood, 1'b1, StEmpty},
    '{SizeCode1k, 1'b0, 1'b1, 1'b0, 2'd2, 8'h01, 8'h22, 32'd7, 32'h200, 32'd7,
      1'b0, SumGood, 1'b1, StOverwritten},
    '{SizeCode1k, 1'b0, 1'b1, 1'b0, 2'd2, 8'h01, 8'h22, 32'd7, 32'h200, 32'd7,
      1'b1, SumGood, 1'b0, StOk},
    '{SizeCode4k, 1'b0, 1'b1, 1'b1, 2'd2, 8'h5A, 8'h82, 32'hFFFF_FFFF, 32'h200,
      32'hFFFF_FFFF, 1'b0, SumGood, 1'b0, StOk},
    '{SizeCodeBad, 1'b1, 1'b1, 1'b0, 2'd1, 8'h01, 8'h22, 32'd0, 32'd0, 32'd0,
      1'b0, SumGood, 1'b1, StBadData},
    '{SizeCode512, 1'b1, 1'b0, 1'b0, 2'd2, 8'h01, 8'h22, 32'd5, 32'h200, 32'd5,
      1'b0, SumBad, 1'b0, StOk},
    '{SizeCode512, 1'b1, 1'b0, 1'b0, 2'd1, 8'h01, 8'h22, 32'd5, 32'd0, 32'd5,
      1'b0, SumGood, 1'b0, StOk},
    '{SizeCode512, 1'b1, 1'b0, 1'b0, 2'd1, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, SumGood, 1'b1, StBadData},
    '{SizeCode512, 1'b1, 1'b1, 1'b0, 2'd2, 8'h00, 8'h22, 32'd0, 32'h200, 32'd0,
      1'b0, SumGood, 1'b0, StOk}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_word_i = '0;
  logic        word_last_i = 1'b0;
  logic [31:0] expected_block_i = '0;
  logic        resync_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  check_status_o;
  logic [31:0] current_sequence_o;
  logic [15:0] computed_sum_o;

  redo_block_header_checker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_word_i       (data_word_i),
    .word_last_i       (word_last_i),
    .expected_block_i  (expected_block_i),
    .resync_i          (resync_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .check_status_o    (check_status_o),
    .current_sequence_o(current_sequence_o),
    .computed_sum_o    (computed_sum_o)
  );

  always #6 clk_i = ~clk_i;

  cfg_t        live_cfg = '{SizeCode512, 1'b1, 1'b1, 1'b0};
  cfg_t        cfg_plan = '{SizeCode512, 1'b1, 1'b1, 1'b0};
  logic [31:0] last_seq = '0;
  logic [63:0] acc_xor = '0;
  logic [63:0] hdr_w0 = '0;
  logic [63:0] hdr_w1 = '0;
  int          word_pos = 0;
  bit          overrun = 1'b0;
  verdict_t    pending_verdicts[$];
  logic [63:0] block_q[$];
  bit          pin_valid = 1'b0;
  status_e     pin_status = StOk;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          words_sent = 0;
  int          mismatches = 0;

  function automatic int counted_words(input logic [1:0] code);
    if (code == SizeCode1k) begin
      return 128;
    end else if (code == SizeCode4k) begin
      return 512;
    end
    return 64;
  endfunction

  function automatic logic [31:0] order32(input logic [31:0] v, input logic swap);
    return swap ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
  endfunction

  function automatic logic [15:0] fold16(input logic [63:0] x);
    return x[15:0] ^ x[31:16] ^ x[47:32] ^ x[63:48];
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin : scoreboard
    verdict_t    v;
    logic [31:0] h_blk;
    logic [31:0] h_seq;
    logic [15:0] h_sum;
    logic [15:0] f;
    logic [7:0]  mk;
    status_e     st;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected status transaction: check_status %0d", check_status_o);
          mismatches++;
        end else begin
          v = pending_verdicts.pop_front();
          if (check_status_o !== v.status) begin
            $error("check_status: expected %0d, actual %0d", v.status, check_status_o);
            mismatches++;
          end
          if (current_sequence_o !== v.seq) begin
            $error("current_sequence: expected %h, actual %h", v.seq, current_sequence_o);
            mismatches++;
          end
          if (computed_sum_o !== v.sum) begin
            $error("computed_sum: expected %h, actual %h", v.sum, computed_sum_o);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgIdxBlockSize: live_cfg.block_size_code = cfg_data_i[1:0];
          CfgIdxArchive:   live_cfg.archive_mode = cfg_data_i[0];
          CfgIdxChecksum:  live_cfg.checksum_enable = cfg_data_i[0];
          CfgIdxBigEndian: live_cfg.big_endian = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        if (!overrun) begin
          if (word_pos == 0) hdr_w0 = data_word_i;
          if (word_pos == 1) hdr_w1 = data_word_i;
          if (word_pos < counted_words(live_cfg.block_size_code)) acc_xor ^= data_word_i;
          if (word_pos < 511) word_pos++;
          else overrun = 1'b1;
        end
        if (word_last_i) begin
          h_blk = order32(hdr_w0[63:32], live_cfg.big_endian);
          h_seq = order32(hdr_w1[31:0], live_cfg.big_endian);
          h_sum = live_cfg.big_endian ? {hdr_w1[55:48], hdr_w1[63:56]} : hdr_w1[63:48];
          f = fold16(acc_xor);
          if (live_cfg.big_endian) f = {f[7:0], f[15:8]};
          v.sum = f ^ h_sum;
          mk = (live_cfg.block_size_code == SizeCode4k) ? MarkerLarge : MarkerSmall;
          if (hdr_w0[15:0] == 16'h0000) begin
            st = StEmpty;
          end else if (live_cfg.block_size_code == SizeCodeBad || hdr_w0[15:8] != mk) begin
            st = StBadData;
          end else begin
            st = StOk;
            if (last_seq == 32'd0 || resync_i) begin
              last_seq = h_seq;
            end else if (live_cfg.archive_mode) begin
              if (last_seq != h_seq) st = StSeqError;
            end else if (last_seq > h_seq) begin
              st = StEmpty;
            end else if (last_seq < h_seq) begin
              st = StOverwritten;
            end
            if (st == StOk && h_blk != expected_block_i) st = StBlockError;
            if (st == StOk && live_cfg.checksum_enable && v.sum != h_sum) st = StChecksumErr;
          end
          v.status = pin_valid ? pin_status : st;
          pin_valid = 1'b0;
          v.seq = last_seq;
          pending_verdicts.push_back(v);
          acc_xor = '0;
          hdr_w0 = '0;
          hdr_w1 = '0;
          word_pos = 0;
          overrun = 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic push_word(input logic [63:0] w, input logic last, input logic [31:0] blk,
                           input logic rs);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_word_i <= w;
    word_last_i <= last;
    expected_block_i <= blk;
    resync_i <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_config(input cfg_t want);
    if (want != cfg_plan) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while (pending_verdicts.size() != 0);
      repeat (4) @(negedge clk_i);
      if (want.block_size_code != cfg_plan.block_size_code) begin
        write_reg(CfgIdxBlockSize, 32'(want.block_size_code));
      end
      if (want.archive_mode != cfg_plan.archive_mode) begin
        write_reg(CfgIdxArchive, 32'(want.archive_mode));
      end
      if (want.checksum_enable != cfg_plan.checksum_enable) begin
        write_reg(CfgIdxChecksum, 32'(want.checksum_enable));
      end
      if (want.big_endian != cfg_plan.big_endian) begin
        write_reg(CfgIdxBigEndian, 32'(want.big_endian));
      end
      cfg_valid_i <= 1'b0;
      cfg_plan = want;
    end
  endtask

  task automatic build_block(input int n, input logic [7:0] b0, input logic [7:0] mk,
                             input logic [31:0] blk, input logic [31:0] seq,
                             input sum_mode_e sum_mode);
    logic [63:0] w;
    logic [63:0] acc;
    int          counted;
    block_q.delete();
    for (int i = 0; i < n; i++) begin
      w = {$urandom, $urandom};
      if (i == 0) w = {order32(blk, cfg_plan.big_endian), w[31:16], mk, b0};
      if (i == 1) w[31:0] = order32(seq, cfg_plan.big_endian);
      block_q.push_back(w);
    end
    if (sum_mode != SumRandom) begin
      // Bytes 2 and 3 are unused by the header, so they absorb the fold.
      acc = '0;
      counted = counted_words(cfg_plan.block_size_code);
      if (n < counted) counted = n;
      for (int i = 0; i < counted; i++) acc ^= block_q[i];
      w = block_q[0];
      w[31:16] = w[31:16] ^ fold16(acc);
      if (sum_mode == SumBad) w[16] = ~w[16];
      block_q[0] = w;
    end
  endtask

  task automatic send_block(input logic [31:0] exp_blk, input logic rs);
    logic last;
    for (int i = 0; i < block_q.size(); i++) begin
      last = (i == block_q.size() - 1);
      push_word(block_q[i], last, last ? exp_blk : $urandom,
                last ? rs : 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_block();
    int          n;
    int          pick;
    logic [7:0]  b0;
    logic [7:0]  mk;
    logic [31:0] exp_blk;
    logic [31:0] blk;
    logic [31:0] seq;
    logic [1:0]  code;
    code = cfg_plan.block_size_code;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      n = $urandom_range(1, 6);
    end else if (pick < 85) begin
      n = $urandom_range(7, 40);
    end else if (code == SizeCode4k) begin
      n = $urandom_range(41, 80);
    end else begin
      n = counted_words(code) + $urandom_range(0, 2) - 1;
    end
    exp_blk = $urandom;
    blk = ($urandom_range(0, 9) < 8) ? exp_blk : $urandom;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      b0 = 8'h00;
      mk = 8'h00;
    end else if (pick == 1) begin
      b0 = 8'($urandom);
      mk = 8'($urandom);
    end else begin
      b0 = 8'($urandom);
      if (code == SizeCode4k) mk = MarkerLarge;
      else if (code == SizeCodeBad) mk = $urandom_range(0, 1) ? MarkerLarge : MarkerSmall;
      else mk = MarkerSmall;
    end
    pick = $urandom_range(0, 19);
    if (pick < 12) seq = last_seq;
    else if (pick < 14) seq = last_seq + 32'd1;
    else if (pick < 16) seq = last_seq - 32'd1;
    else if (pick == 16) seq = 32'd0;
    else seq = $urandom;
    build_block(n, b0, mk, blk, seq, ($urandom_range(0, 9) < 8) ? SumGood : SumRandom);
    send_block(exp_blk, ($urandom_range(0, 9) == 0));
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.block_size_code = 2'($urandom_range(0, 3));
    c.archive_mode = 1'($urandom_range(0, 1));
    c.checksum_enable = 1'($urandom_range(0, 1));
    c.big_endian = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic run_phase(input int tx_pct, input int rx_pct, input int upto);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (words_sent < upto) begin
      if ($urandom_range(0, 5) == 0) set_config(random_cfg());
      random_block();
    end
  endtask

  initial begin : stimulus
    cfg_t        big_cfg;
    logic [31:0] exp_blk;
    tx_idle_pct = 38;
    rx_idle_pct = 62;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (Plan[i]) begin
      set_config('{Plan[i].size_code, Plan[i].archive, Plan[i].cks_en, Plan[i].big_end});
      build_block(Plan[i].words, Plan[i].b0, Plan[i].marker, Plan[i].blk, Plan[i].seq,
                  Plan[i].sum_mode);
      pin_valid = Plan[i].pinned;
      pin_status = Plan[i].status;
      send_block(Plan[i].exp_blk, Plan[i].resync);
    end
    run_phase(38, 62, 450);
    run_phase(62, 38, 900);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // One 4 KB block of 515 words that runs past the word counter's end.
    big_cfg = random_cfg();
    big_cfg.block_size_code = SizeCode4k;
    set_config(big_cfg);
    exp_blk = $urandom;
    build_block(515, 8'($urandom), MarkerLarge, exp_blk, last_seq, SumGood);
    send_block(exp_blk, 1'b0);
    run_phase(0, 0, 1450);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_verdicts.size() != 0);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
